[rtl/row_profile_edge_finder_defines.svh]
// assertion macros for the row profile edge finder
// used by the top level only
`ifndef ROW_PROFILE_EDGE_FINDER_DEFINES_SVH
`define ROW_PROFILE_EDGE_FINDER_DEFINES_SVH
`ifndef SYNTHESIS
`define RPEF_ASSERT_IMPL(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error("%m failed");
`define RPEF_ASSERT_NORST(label, clk, prop) \
   label: assert property (@(posedge clk) prop) else $error("%m failed");
`else
`define RPEF_ASSERT_IMPL(label, clk, rst, prop)
`define RPEF_ASSERT_NORST(label, clk, prop)
`endif
`endif

[rtl/rpef_pkg.sv]
// shared types and constants for the row profile edge finder
// no dependencies
`default_nettype none
package rpef_pkg;
   localparam int CFG_IDX_W = 2;
   localparam logic [CFG_IDX_W-1:0] REG_WINDOW_START = 2'd0;
   localparam logic [CFG_IDX_W-1:0] REG_WINDOW_WIDTH = 2'd1;
   localparam logic [CFG_IDX_W-1:0] REG_PEAK_COUNT   = 2'd2;
   localparam logic [CFG_IDX_W-1:0] REG_GAIN         = 2'd3;

   typedef enum logic [3:0] {
      ST_STREAM,
      ST_DIV,
      ST_WRITE,
      ST_WALK_RD,
      ST_WALK,
      ST_AVG,
      ST_DN_RD,
      ST_DN,
      ST_UP_RD,
      ST_UP,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic start;
      logic busy;
      logic done;
   } div_ctl_type;
endpackage
`default_nettype wire

[rtl/row_profile_edge_finder.sv]
// row profile edge finder
// req beat: one pixel; rsp beat: edges, reference average and status after the
// last pixel of an image. pixels stream one per cycle except at row ends: after
// the last pixel of a row is taken, the row's window sum goes through the shared
// serial divider and is written to the profile memory, and req_tready stays low
// meanwhile.
// at end of image the sequencer walks the profile, then divides the walked sum
// through the divider, then runs the down search and the up search; rsp_tvalid
// then rises and the result stays in its registers until taken. one image at a
// time.
// reset (synchronous, high) clears the state, the column and row counters and
// the window sum and sets the csr registers to defaults; the profile memory needs
// no clearing. while rsp_tready is low the result stays and no new pixel is taken.
// csr writes are taken whenever the block is streaming pixels (csr_ready high).
// the deviation test uses one 16 by 8 multiplier.
`default_nettype none
module row_profile_edge_finder #(
   parameter int MAX_ROWS = 1024,
   parameter int MAX_COLS = 4096
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,  // pixel
   input  wire logic        req_tlast,  // end_of_row
   input  wire logic        req_tuser,  // end_of_image
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [31:0]      rsp_tdata,  // up_edge, down_edge, reference_average, status
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [15:0] csr_data
);
   import rpef_pkg::*;
   localparam int AW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int RW = $clog2(MAX_ROWS + 1);
   localparam int CW = $clog2(MAX_COLS + 1);
   localparam int XW = (CW > 13) ? CW : 13;
   localparam int SW = (RW + 8 > 20) ? RW + 8 : 20;
   localparam int DDW = (RW > 12) ? RW : 12;

   logic [11:0] wstart_ff, wwidth_ff;
   logic [5:0]  pcount_ff;
   logic [15:0] gain_ff;

   state_type   st_ff, st_in;
   logic [CW-1:0] col_ff, col_in;
   logic [RW-1:0] rows_ff, rows_in;
   logic [SW-1:0] sum_ff, sum_in;
   logic          eoi_ff, eoi_in;
   logic [RW-1:0] idx_ff, idx_in, mid_ff, mid_in;
   logic [7:0]    prevv_ff, prevv_in, avg_ff, avg_in;
   logic          prise_ff, prise_in, prevdev_ff, prevdev_in, found_ff, found_in;
   logic [6:0]    k_ff, k_in;
   logic [RW-1:0] walked_ff, walked_in, up_ff, up_in, down_ff, down_in;
   logic          stat_ff, stat_in;

   logic           div_start;
   logic [SW-1:0]  div_num, quot;
   logic [DDW-1:0] div_den;
   div_ctl_type    dctl;
   logic           wr_en;
   logic [AW-1:0]  rd_addr;
   logic [7:0]     rd_data;
   logic           acc, dev, rise, in_win, dn_more;
   logic [12:0]    wend;
   logic [XW-1:0]  col_x, wstart_x, wend_x;
   logic [7:0]     diff;
   logic [19:0]    lhs;
   logic [23:0]    rhs;

   rpef_divider #(.NW(SW), .DW(DDW)) u_div (
      .clock, .reset, .start(div_start), .numer(div_num), .denom(div_den),
      .ctl(dctl), .quot);

   rpef_profile_ram #(.DEPTH(MAX_ROWS), .AW(AW)) u_ram (
      .clock, .wr_en, .wr_addr(rows_ff[AW-1:0]), .wr_data(quot[7:0]),
      .rd_addr, .rd_data);

   assign acc = req_tvalid && req_tready;
   assign wend = {1'b0, wstart_ff} + {1'b0, wwidth_ff};
   assign col_x = XW'(col_ff);
   assign wstart_x = XW'(wstart_ff);
   assign wend_x = XW'(wend);
   assign in_win = (col_ff < CW'(MAX_COLS)) && (col_x >= wstart_x) && (col_x < wend_x);
   assign diff = (avg_ff > rd_data) ? avg_ff - rd_data : rd_data - avg_ff;
   assign lhs = {diff, 12'd0};
   assign rhs = avg_ff * gain_ff;
   assign dev = {4'd0, lhs} > rhs;
   assign rise = (idx_ff != '0) && (rd_data > prevv_ff);
   assign dn_more = (idx_ff < rows_ff) && !found_ff;

   always_comb begin
      st_in = st_ff;
      case (st_ff)
         ST_STREAM: if (acc && (req_tlast || req_tuser)) st_in = ST_DIV;
         ST_DIV:    if (dctl.done) st_in = ST_WRITE;
         ST_WRITE:  st_in = eoi_ff ? ST_WALK_RD : ST_STREAM;
         ST_WALK_RD: st_in = (k_ff < {1'b0, pcount_ff} && idx_ff < rows_ff) ?
                             ST_WALK : ST_AVG;
         ST_WALK:   st_in = ST_WALK_RD;
         ST_AVG:    if (dctl.done) st_in = ST_DN_RD;
         ST_DN_RD:  st_in = dn_more ? ST_DN : ST_UP_RD;
         ST_DN:     st_in = ST_DN_RD;
         ST_UP_RD:  st_in = ST_UP;
         ST_UP:     st_in = ((prevdev_ff && dev) || idx_ff == '0) ? ST_OUT : ST_UP_RD;
         ST_OUT:    if (rsp_tready) st_in = ST_STREAM;
         default:   st_in = ST_STREAM;
      endcase
   end

   always_comb begin
      col_in = col_ff; rows_in = rows_ff; sum_in = sum_ff; eoi_in = eoi_ff;
      idx_in = idx_ff; mid_in = mid_ff; prevv_in = prevv_ff; avg_in = avg_ff;
      prise_in = prise_ff; prevdev_in = prevdev_ff; found_in = found_ff; k_in = k_ff;
      walked_in = walked_ff; up_in = up_ff; down_in = down_ff; stat_in = stat_ff;
      div_start = 1'b0; div_num = sum_ff;
      div_den = (wwidth_ff == 12'd0) ? DDW'(1) : DDW'(wwidth_ff);
      wr_en = 1'b0; rd_addr = idx_ff[AW-1:0];
      case (st_ff)
         ST_STREAM: if (acc) begin
            if (in_win) sum_in = sum_ff + SW'(req_tdata);
            if (col_ff < CW'(MAX_COLS)) col_in = col_ff + 1'b1;
            eoi_in = req_tuser;
            if (req_tlast || req_tuser) begin
               div_start = 1'b1;
               div_num = sum_in;
            end
         end
         ST_WRITE: begin
            wr_en = (rows_ff < RW'(MAX_ROWS));
            rows_in = wr_en ? rows_ff + 1'b1 : rows_ff;
            col_in = '0; sum_in = '0;
            idx_in = rows_in >> 1;
            mid_in = idx_in;
            k_in = '0; walked_in = '0; prise_in = 1'b0;
            // row above the middle, lands in rd_data for the first walk step
            rd_addr = (idx_in == '0) ? '0 : AW'(idx_in - 1'b1);
         end
         ST_WALK_RD: begin
            if (walked_ff == '0) prevv_in = rd_data;
         end
         ST_WALK: begin
            if (!rise && prise_ff) k_in = k_ff + 1'b1;
            prise_in = rise;
            sum_in = sum_ff + SW'(rd_data);
            walked_in = walked_ff + 1'b1;
            prevv_in = rd_data;
            idx_in = idx_ff + 1'b1;
         end
         ST_AVG: begin
            if (!dctl.busy && !dctl.done) begin
               div_start = 1'b1;
               div_num = sum_ff;
               div_den = (walked_ff == '0) ? DDW'(1) : DDW'(walked_ff);
            end
            if (dctl.done) begin
               avg_in = quot[7:0];
               stat_in = k_ff < {1'b0, pcount_ff};
               idx_in = mid_ff; down_in = mid_ff; up_in = mid_ff;
               found_in = 1'b0; prevdev_in = 1'b0;
            end
         end
         ST_DN_RD: begin
            // prepare up search
            if (!dn_more) begin
               idx_in = mid_ff; prevdev_in = 1'b0;
            end
         end
         ST_DN: begin
            if (prevdev_ff && dev) begin
               down_in = idx_ff - 1'b1; found_in = 1'b1;
            end else begin
               prevdev_in = dev; idx_in = idx_ff + 1'b1;
            end
         end
         ST_UP: begin
            if (prevdev_ff && dev) up_in = idx_ff + 1'b1;
            else begin
               prevdev_in = dev; idx_in = idx_ff - 1'b1;
            end
         end
         ST_OUT: if (rsp_tready) begin
            rows_in = '0; col_in = '0; sum_in = '0;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_STREAM;
         col_ff <= '0; rows_ff <= '0; sum_ff <= '0;
         wstart_ff <= 12'd0; wwidth_ff <= 12'd10; pcount_ff <= 6'd6; gain_ff <= 16'd1024;
      end else begin
         st_ff <= st_in;
         col_ff <= col_in; rows_ff <= rows_in; sum_ff <= sum_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_WINDOW_START: wstart_ff <= csr_data[11:0];
               REG_WINDOW_WIDTH: wwidth_ff <= csr_data[11:0];
               REG_PEAK_COUNT:   pcount_ff <= csr_data[5:0];
               REG_GAIN:         gain_ff <= csr_data;
               default: ;
            endcase
         end
      end
      eoi_ff <= eoi_in; idx_ff <= idx_in; mid_ff <= mid_in; prevv_ff <= prevv_in;
      avg_ff <= avg_in; prise_ff <= prise_in; prevdev_ff <= prevdev_in;
      found_ff <= found_in; k_ff <= k_in; walked_ff <= walked_in; up_ff <= up_in;
      down_ff <= down_in; stat_ff <= stat_in;
   end

   always_comb begin
      req_tready = (st_ff == ST_STREAM);
      csr_ready = (st_ff == ST_STREAM);
      rsp_tvalid = (st_ff == ST_OUT);
      rsp_tdata = {3'd0, stat_ff, avg_ff, 10'(down_ff), 10'(up_ff)};
   end

   `include "row_profile_edge_finder_defines.svh"
   `RPEF_ASSERT_IMPL(a_no_overlap, clock, reset, !(req_tready && rsp_tvalid))
   `RPEF_ASSERT_IMPL(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid)
   `RPEF_ASSERT_IMPL(a_rows_bound, clock, reset, rows_ff <= RW'(MAX_ROWS))
endmodule
`default_nettype wire

[rtl/rpef_divider.sv]
// restoring divider, one quotient bit per cycle
// depends on rpef_pkg
`default_nettype none
module rpef_divider #(
   parameter int NW = 32,
   parameter int DW = 12
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   input  wire logic [NW-1:0]       numer,
   input  wire logic [DW-1:0]       denom,
   output rpef_pkg::div_ctl_type    ctl,
   output logic      [NW-1:0]       quot
);
   import rpef_pkg::*;
   localparam int CW = $clog2(NW + 1);
   logic [NW-1:0] q_ff, q_in;
   logic [DW:0]   r_ff, r_in;
   logic [DW-1:0] d_ff, d_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          busy_ff, busy_in, done_ff, done_in;
   logic [DW:0]   trial;

   always_comb begin
      q_in = q_ff;
      r_in = r_ff;
      d_in = d_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial = {r_ff[DW-1:0], q_ff[NW-1]};
      if (start) begin
         q_in = numer;
         r_in = '0;
         d_in = denom;
         cnt_in = CW'(NW);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, d_ff}) begin
            r_in = trial - {1'b0, d_ff};
            q_in = {q_ff[NW-2:0], 1'b1};
         end else begin
            r_in = trial;
            q_in = {q_ff[NW-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff <= cnt_in;
      end
      q_ff <= q_in;
      r_ff <= r_in;
      d_ff <= d_in;
   end

   assign quot = q_ff;
   assign ctl.start = start;
   assign ctl.busy = busy_ff;
   assign ctl.done = done_ff;
endmodule
`default_nettype wire

[rtl/rpef_profile_ram.sv]
// row profile store, one write and one registered read port
// depends on nothing
`default_nettype none
module rpef_profile_ram #(
   parameter int DEPTH = 1024,
   parameter int AW = 10
) (
   input  wire logic          clock,
   input  wire logic          wr_en,
   input  wire logic [AW-1:0] wr_addr,
   input  wire logic [7:0]    wr_data,
   input  wire logic [AW-1:0] rd_addr,
   output logic      [7:0]    rd_data
);
   logic [7:0] mem [DEPTH];
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire
